// ----- hw/rtl/tadc_pkg.sv -----
// ----------------------------------------------------------------------------
// tadc_pkg - shared constants, types and functions of the thermistor converter
// Holds the resistance/temperature table, the field widths and the tag that
// travels with an item through the interpolation divider.
// ----------------------------------------------------------------------------
package tadc_pkg;

  localparam int STORED_POINTS    = 18;
  localparam int TABLE_POINTS_DEF = 18;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int MV_W      = 12;
  localparam int TEMP_W    = 12;
  localparam int SUPPLY_MV = 3300;

  // Width of the supply-minus-voltage divisor and of 10*mv (at most 40950).
  localparam int DEN1_W  = 12;
  localparam int MVX10_W = 16;

  // A resistance inside the table is below 256 k, a segment span below 128 k.
  localparam int SEG_INT_W = 8;

  // The interpolation offset never exceeds 100 tenths.
  localparam int OFF_W = 7;

  // Register stages of the segment locator.
  localparam int SEG_STAGES = 5;

  localparam int RES_W    = 22;
  localparam int PT_SCALE = 10000;

  localparam int TOP_TENTHS  = 1300;
  localparam int STEP_TENTHS = 100;
  localparam int MIN_TENTHS  = -400;

  localparam int IDX_W = $clog2(STORED_POINTS);

  typedef logic [RES_W-1:0] res_arr_t [STORED_POINTS];

  // Resistance in units of 1/10000 kilohm, ascending; temperature descends
  // from 130 C in 10 degree steps.
  localparam res_arr_t RES_TABLE = '{
    22'd3952,   22'd5046,   22'd6510,   22'd8502,    22'd11240,   22'd15060,
    22'd20470,  22'd28230,  22'd39580,  22'd56480,   22'd82210,   22'd121240,
    22'd186800, 22'd293700, 22'd477300, 22'd803600,  22'd1400000, 22'd2496000
  };

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
  } seg_tag_t;

  // Fixed-point value of a table point, rounded half up.
  function automatic logic [63:0] point_fx(int idx, int frac);
    logic [63:0] v;
    v = 64'(RES_TABLE[idx]) << frac;
    return (v + 64'(PT_SCALE / 2)) / 64'(PT_SCALE);
  endfunction

  // Temperature of a table point in tenths of a degree.
  function automatic logic signed [TEMP_W-1:0] point_temp(logic [IDX_W-1:0] idx);
    return TEMP_W'(TOP_TENTHS - STEP_TENTHS * int'(idx));
  endfunction

endpackage

// ----- hw/rtl/tadc_div.sv -----
// ----------------------------------------------------------------------------
// tadc_div - pipelined restoring divider
// Resolves one quotient bit per register stage and carries a tag alongside.
// The upper DEN_W bits of the numerator must be below the divisor.
// ----------------------------------------------------------------------------
module tadc_div
  import tadc_pkg::*;
#(
  parameter int DEN_W = DEN1_W,
  parameter int Q_W   = OFF_W,
  parameter int TAG_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [Q_W+DEN_W-1:0]   in_num,
  input  logic [DEN_W-1:0]       in_den,
  input  logic [TAG_W-1:0]       in_tag,
  output logic                   out_valid,
  output logic [Q_W-1:0]         out_quo,
  output logic [TAG_W-1:0]       out_tag
);

  logic             vld_r   [Q_W];
  logic [DEN_W-1:0] rem_r   [Q_W];
  logic [Q_W-1:0]   low_r   [Q_W];
  logic [DEN_W-1:0] den_r   [Q_W];
  logic [TAG_W-1:0] tag_r   [Q_W];

  logic             vld_nxt [Q_W];
  logic [DEN_W-1:0] rem_in  [Q_W];
  logic [Q_W-1:0]   low_in  [Q_W];
  logic [DEN_W-1:0] den_nxt [Q_W];
  logic [TAG_W-1:0] tag_nxt [Q_W];
  logic [DEN_W:0]   trial   [Q_W];
  logic             ge      [Q_W];
  logic [DEN_W-1:0] rem_nxt [Q_W];
  logic [Q_W-1:0]   low_nxt [Q_W];

  always_comb begin
    vld_nxt[0] = in_valid;
    rem_in[0]  = in_num[Q_W+DEN_W-1:Q_W];
    low_in[0]  = in_num[Q_W-1:0];
    den_nxt[0] = in_den;
    tag_nxt[0] = in_tag;
    for (int s = 1; s < Q_W; s++) begin
      vld_nxt[s] = vld_r[s-1];
      rem_in[s]  = rem_r[s-1];
      low_in[s]  = low_r[s-1];
      den_nxt[s] = den_r[s-1];
      tag_nxt[s] = tag_r[s-1];
    end
    // Each stage shifts in one numerator bit and tries one subtraction.
    for (int s = 0; s < Q_W; s++) begin
      trial[s]   = {rem_in[s], low_in[s][Q_W-1]};
      ge[s]      = trial[s] >= {1'b0, den_nxt[s]};
      rem_nxt[s] = ge[s] ? DEN_W'(trial[s] - {1'b0, den_nxt[s]}) : DEN_W'(trial[s]);
      low_nxt[s] = {low_in[s][Q_W-2:0], ge[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < Q_W; s++) vld_r[s] <= 1'b0;
    end else begin
      for (int s = 0; s < Q_W; s++) vld_r[s] <= vld_nxt[s];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < Q_W; s++) begin
      rem_r[s] <= rem_nxt[s];
      low_r[s] <= low_nxt[s];
      den_r[s] <= den_nxt[s];
      tag_r[s] <= tag_nxt[s];
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_quo   = low_r[Q_W-1];
  assign out_tag   = tag_r[Q_W-1];

endmodule

// ----- hw/rtl/tadc_seg.sv -----
// ----------------------------------------------------------------------------
// tadc_seg - table segment locator
// Compares the resistance against the table points, picks the bracketing
// segment and forms the numerator and divisor of the rounded offset.
// ----------------------------------------------------------------------------
module tadc_seg
  import tadc_pkg::*;
#(
  parameter int TABLE_POINTS = TABLE_POINTS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic [MVX10_W+FRAC_BITS-1:0]           in_res,
  input  logic                                   in_mv_ok,
  output logic                                   out_valid,
  output logic [OFF_W+SEG_INT_W+FRAC_BITS-1:0]   out_num,
  output logic [SEG_INT_W+FRAC_BITS-1:0]         out_den,
  output seg_tag_t                               out_tag
);

  localparam int Q1_W   = MVX10_W + FRAC_BITS;
  localparam int RW     = SEG_INT_W + FRAC_BITS;
  localparam int NUM2_W = OFF_W + RW;
  localparam int COUNT  = (TABLE_POINTS < STORED_POINTS) ? TABLE_POINTS : STORED_POINTS;

  logic [RW-1:0] pt_tbl [STORED_POINTS];

  for (genvar g = 0; g < STORED_POINTS; g++) begin : g_pt
    assign pt_tbl[g] = RW'(point_fx(g, FRAC_BITS));
  end

  // Stage A: compare against every point up to TABLE_POINTS.
  logic                     sa_vld_r;
  logic                     sa_mv_ok_r, sa_below_r, sa_above_r;
  logic [STORED_POINTS-1:0] sa_lt_r;
  logic [RW-1:0]            sa_res_r;
  logic                     sa_below_nxt, sa_above_nxt;
  logic [STORED_POINTS-1:0] sa_lt_nxt;

  // Only interior points are counted, so the index is bounded to the last
  // segment and a value equal to the first point lands in segment zero.
  always_comb begin
    sa_lt_nxt = '0;
    for (int i = 1; i < COUNT - 1; i++) begin
      sa_lt_nxt[i] = Q1_W'(pt_tbl[i]) < in_res;
    end
    sa_below_nxt = in_res < Q1_W'(pt_tbl[0]);
    sa_above_nxt = Q1_W'(pt_tbl[COUNT-1]) < in_res;
  end

  // Stage B: segment index.
  logic          sb_vld_r;
  seg_tag_t      sb_tag_r, sb_tag_nxt;
  logic [RW-1:0] sb_res_r;

  always_comb begin
    sb_tag_nxt.ok  = sa_mv_ok_r & ~sa_below_r & ~sa_above_r;
    sb_tag_nxt.idx = IDX_W'($countones(sa_lt_r));
  end

  // Stage C: fetch segment end points.
  logic          sc_vld_r;
  seg_tag_t      sc_tag_r;
  logic [RW-1:0] sc_res_r, sc_t0_r, sc_t1_r;
  logic [RW-1:0] sc_t0_nxt, sc_t1_nxt;

  always_comb begin
    sc_t0_nxt = pt_tbl[sb_tag_r.idx];
    sc_t1_nxt = pt_tbl[sb_tag_r.idx + IDX_W'(1)];
  end

  // Stage D: distance into the segment and segment span.
  logic          sd_vld_r;
  seg_tag_t      sd_tag_r;
  logic [RW-1:0] sd_x_r, sd_span_r;
  logic [RW-1:0] sd_x_nxt, sd_span_nxt;

  always_comb begin
    sd_x_nxt    = sc_res_r - sc_t0_r;
    sd_span_nxt = sc_t1_r - sc_t0_r;
  end

  // Stage E: numerator 200*x + span and divisor 2*span for a rounded quotient.
  logic              se_vld_r;
  seg_tag_t          se_tag_r;
  logic [NUM2_W-1:0] se_num_r, se_num_nxt;
  logic [RW-1:0]     se_den_r, se_den_nxt;

  always_comb begin
    se_num_nxt = (NUM2_W'(sd_x_r) << 7) + (NUM2_W'(sd_x_r) << 6)
               + (NUM2_W'(sd_x_r) << 3) + NUM2_W'(sd_span_r);
    se_den_nxt = {sd_span_r[RW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r <= 1'b0;
      sb_vld_r <= 1'b0;
      sc_vld_r <= 1'b0;
      sd_vld_r <= 1'b0;
      se_vld_r <= 1'b0;
    end else begin
      sa_vld_r <= in_valid;
      sb_vld_r <= sa_vld_r;
      sc_vld_r <= sb_vld_r;
      sd_vld_r <= sc_vld_r;
      se_vld_r <= sd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sa_mv_ok_r <= in_mv_ok;
    sa_below_r <= sa_below_nxt;
    sa_above_r <= sa_above_nxt;
    sa_lt_r    <= sa_lt_nxt;
    sa_res_r   <= in_res[RW-1:0];
    sb_tag_r   <= sb_tag_nxt;
    sb_res_r   <= sa_res_r;
    sc_tag_r   <= sb_tag_r;
    sc_res_r   <= sb_res_r;
    sc_t0_r    <= sc_t0_nxt;
    sc_t1_r    <= sc_t1_nxt;
    sd_tag_r   <= sc_tag_r;
    sd_x_r     <= sd_x_nxt;
    sd_span_r  <= sd_span_nxt;
    se_tag_r   <= sd_tag_r;
    se_num_r   <= se_num_nxt;
    se_den_r   <= se_den_nxt;
  end

  assign out_valid = se_vld_r;
  assign out_num   = se_num_r;
  assign out_den   = se_den_r;
  assign out_tag   = se_tag_r;

endmodule

// ----- hw/rtl/thermistor_adc_to_temperature.sv -----
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature - NTC divider voltage to temperature
// Converts a divider voltage in millivolts into tenths of a degree Celsius by
// table lookup and linear interpolation, fully pipelined.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                        | Handshake
//  ---------+----------------------------------------------+---------------------------
//  input    | start, busy, in_adc_mv                       | start high, busy low
//  result   | out_valid, out_temp_tenths, out_in_range     | one-cycle strobe, no stall
//
// One item may be started in every cycle. Each item passes through the input
// register, the resistance divider, which resolves one of its 16 + FRAC_BITS
// quotient bits per stage, the five locator stages, the seven-stage offset
// divider and the output register. Reset is synchronous and clears every
// valid bit; busy is high only while reset is held. The receiver cannot
// stall, so the pipeline never stops.
//
module thermistor_adc_to_temperature
  import tadc_pkg::*;
#(
  parameter int TABLE_POINTS = TABLE_POINTS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [MV_W-1:0]          in_adc_mv,
  output logic                     out_valid,
  output logic signed [TEMP_W-1:0] out_temp_tenths,
  output logic                     out_in_range
);

  localparam int Q1_W    = MVX10_W + FRAC_BITS;
  localparam int RW      = SEG_INT_W + FRAC_BITS;
  localparam int NUM2_W  = OFF_W + RW;
  localparam int TAG_W   = $bits(seg_tag_t);
  localparam int LATENCY = 1 + Q1_W + SEG_STAGES + OFF_W + 1;

  // The pipeline never holds an item back, so the only time no item is
  // taken is while reset is applied.
  assign busy = ~rst_n;

  // Input register.
  logic            s0_vld_r;
  logic [MV_W-1:0] s0_mv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_mv_r <= in_adc_mv;
  end

  // Resistance R = 10*mv / (3300 - mv) in kilohms with FRAC_BITS fraction
  // bits. A voltage at or above the supply is flagged here; the divider
  // result for it is ignored downstream.
  logic [MVX10_W-1:0]     mv_x10;
  logic [DEN1_W+Q1_W-1:0] div1_num;
  logic [DEN1_W-1:0]      div1_den;
  logic [0:0]             div1_tag;

  always_comb begin
    mv_x10   = (MVX10_W'(s0_mv_r) << 3) + (MVX10_W'(s0_mv_r) << 1);
    div1_num = {DEN1_W'(0), mv_x10, FRAC_BITS'(0)};
    div1_den = DEN1_W'(SUPPLY_MV) - s0_mv_r;
    div1_tag = s0_mv_r < MV_W'(SUPPLY_MV);
  end

  logic            res_vld;
  logic [Q1_W-1:0] res_val;
  logic [0:0]      res_tag;

  tadc_div #(
    .DEN_W (DEN1_W),
    .Q_W   (Q1_W),
    .TAG_W (1)
  ) u_res_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_vld_r),
    .in_num    (div1_num),
    .in_den    (div1_den),
    .in_tag    (div1_tag),
    .out_valid (res_vld),
    .out_quo   (res_val),
    .out_tag   (res_tag)
  );

  // Segment search and operand preparation for the interpolation.
  logic              seg_vld;
  logic [NUM2_W-1:0] seg_num;
  logic [RW-1:0]     seg_den;
  seg_tag_t          seg_tag;

  tadc_seg #(
    .TABLE_POINTS (TABLE_POINTS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (res_vld),
    .in_res    (res_val),
    .in_mv_ok  (res_tag[0]),
    .out_valid (seg_vld),
    .out_num   (seg_num),
    .out_den   (seg_den),
    .out_tag   (seg_tag)
  );

  // Rounded offset in tenths: (200*x + span) / (2*span), never above 100.
  // The table is strictly ascending, so the span is never zero.
  logic             off_vld;
  logic [OFF_W-1:0] off_val;
  logic [TAG_W-1:0] off_tag_raw;
  seg_tag_t         off_tag;

  tadc_div #(
    .DEN_W (RW),
    .Q_W   (OFF_W),
    .TAG_W (TAG_W)
  ) u_off_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (seg_vld),
    .in_num    (seg_num),
    .in_den    (seg_den),
    .in_tag    (seg_tag),
    .out_valid (off_vld),
    .out_quo   (off_val),
    .out_tag   (off_tag_raw)
  );

  assign off_tag = off_tag_raw;

  // Output register: the segment start temperature minus the offset, or zero
  // with the range flag clear when the voltage is at or above the supply or the resistance is off the table.
  logic                     out_vld_r;
  logic signed [TEMP_W-1:0] out_temp_r, out_temp_nxt;
  logic                     out_range_r;

  always_comb begin
    if (off_tag.ok) begin
      out_temp_nxt = point_temp(off_tag.idx) - $signed(TEMP_W'(off_val));
    end else begin
      out_temp_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= off_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_temp_r  <= out_temp_nxt;
    out_range_r <= off_tag.ok;
  end

  assign out_valid       = out_vld_r;
  assign out_temp_tenths = out_temp_r;
  assign out_in_range    = out_range_r;

  // Every accepted item comes out after the fixed latency.
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted item did not come out after the pipeline latency");

  // No result appears without an item accepted that long before.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching accepted item");

  // A voltage at or above the supply is never reported in range.
  a_supply: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_adc_mv >= MV_W'(SUPPLY_MV))) |-> ##LATENCY !out_in_range)
    else $error("voltage above supply reported in range");

  // An in-range temperature lies within the table span.
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_range) |->
      ((out_temp_tenths >= MIN_TENTHS) && (out_temp_tenths <= TOP_TENTHS)))
    else $error("in-range temperature outside the table span");

endmodule

// ----- bench/thermistor_adc_to_temperature_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature_tb - self-checking bench for the NTC converter
// Drives divider voltages through the command port, predicts each temperature
// and range flag with an independent fixed-point model of the lookup and
// interpolation, and compares every result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature_tb;
  import tadc_pkg::*;

  // The bench runs the block at its default table size and precision.
  localparam int KNOTS       = 18;
  localparam int FRAC        = 16;
  localparam int SUPPLY      = 3300;
  localparam int RANDOM_ITEMS = 1750;
  localparam int NUM_PROBES  = 22;
  // Cycles without any accepted item or result before the run is abandoned.
  // The slowest correct stretch is a long sender gap plus the pipeline
  // latency, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = FRAC + 40;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic                     in_range;
  } reading_t;

  typedef struct {
    logic [MV_W-1:0]          mv;
    bit                       known;
    logic signed [TEMP_W-1:0] temp;
    logic                     in_range;
  } probe_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic [MV_W-1:0]          in_adc_mv = '0;
  logic                     busy;
  logic                     out_valid;
  logic signed [TEMP_W-1:0] out_temp_tenths;
  logic                     out_in_range;

  // Predictions in acceptance order; the pipeline never reorders items.
  reading_t pending_readings [$];
  reading_t oldest;
  probe_t   probes [NUM_PROBES];
  int       fail_count   = 0;
  int       quiet_cycles = 0;

  thermistor_adc_to_temperature #(
    .TABLE_POINTS(KNOTS),
    .FRAC_BITS   (FRAC)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_adc_mv      (in_adc_mv),
    .out_valid      (out_valid),
    .out_temp_tenths(out_temp_tenths),
    .out_in_range   (out_in_range)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Thermistor resistance at each 10 degree step, in 1/10000 kilohm, from
  // 130 C down to -40 C. Resistance rises as the temperature falls.
  function automatic longint unsigned knot_res(int idx);
    case (idx)
      0:       return 3952;
      1:       return 5046;
      2:       return 6510;
      3:       return 8502;
      4:       return 11240;
      5:       return 15060;
      6:       return 20470;
      7:       return 28230;
      8:       return 39580;
      9:       return 56480;
      10:      return 82210;
      11:      return 121240;
      12:      return 186800;
      13:      return 293700;
      14:      return 477300;
      15:      return 803600;
      16:      return 1400000;
      default: return 2496000;
    endcase
  endfunction

  // A table resistance in the block's fixed-point kilohm format, rounded to
  // the nearest step with halves going up.
  function automatic longint unsigned knot_fx(int idx);
    return ((knot_res(idx) << FRAC) + 64'd5000) / 64'd10000;
  endfunction

  // Divider voltage to temperature: resistance from the 10 k divider, then
  // the first table segment that holds it (bounds inclusive), then a
  // rounded linear step back from the segment's warm end.
  function automatic reading_t mv_to_reading(logic [MV_W-1:0] mv);
    reading_t        res;
    longint unsigned r_fx;
    longint unsigned lo_fx;
    longint unsigned hi_fx;
    longint unsigned span;
    longint unsigned offset;
    int              seg;
    res.temp     = '0;
    res.in_range = 1'b0;
    if (int'(mv) < SUPPLY) begin
      r_fx = ((64'(mv) * 64'd10) << FRAC) / (64'(SUPPLY) - 64'(mv));
      if (r_fx >= knot_fx(0) && r_fx <= knot_fx(KNOTS - 1)) begin
        for (seg = 0; seg < KNOTS - 1 && !res.in_range; seg++) begin
          lo_fx = knot_fx(seg);
          hi_fx = knot_fx(seg + 1);
          if (r_fx >= lo_fx && r_fx <= hi_fx) begin
            span   = hi_fx - lo_fx;
            offset = (span == 0) ? 64'd0 :
                     ((r_fx - lo_fx) * 64'd200 + span) / (64'd2 * span);
            res.temp     = TEMP_W'(1300 - 100 * seg - int'(offset));
            res.in_range = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  // Presents one item and holds it until the block takes it. The item is
  // accepted at the edge where start is high and busy was low just before.
  // The expectation is queued at that same edge; with the pipeline latency
  // it can never be needed by the result check in the same cycle.
  task automatic send_mv(input logic [MV_W-1:0] mv, input bit known,
                         input logic signed [TEMP_W-1:0] temp, input logic rng);
    reading_t want;
    start     <= 1'b1;
    in_adc_mv <= mv;
    do @(posedge clk); while (busy);
    if (known) begin
      want.temp     = temp;
      want.in_range = rng;
    end else begin
      want = mv_to_reading(mv);
    end
    pending_readings.push_back(want);
  endtask

  // Drops start for the given number of cycles. A zero gap leaves start
  // high so that the next item follows back to back.
  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  // Most voltages land inside the table span, where the interesting
  // interpolation happens; some hug the two ends of the span and the rest
  // cover the whole 12-bit field, including voltages at or above supply.
  function automatic logic [MV_W-1:0] pick_mv();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return MV_W'($urandom_range(126, 3172));
    if (roll < 85) return MV_W'($urandom_range(115, 140));
    if (roll < 90) return MV_W'($urandom_range(3160, 3310));
    return MV_W'($urandom_range(0, 4095));
  endfunction

  // Result check. A strobe with nothing waiting, or any field that differs
  // from the oldest prediction, counts as a failure; the run carries on.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_readings.size() == 0) begin
        $error("result with no item outstanding: temp_tenths=%0d in_range=%0b",
               out_temp_tenths, out_in_range);
        fail_count++;
      end else begin
        oldest = pending_readings.pop_front();
        if (out_temp_tenths !== oldest.temp) begin
          $error("temp_tenths: expected %0d, actual %0d", oldest.temp, out_temp_tenths);
          fail_count++;
        end
        if (out_in_range !== oldest.in_range) begin
          $error("in_range: expected %0b, actual %0b", oldest.in_range, out_in_range);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any accepted item or result restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("thermistor_adc_to_temperature test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    int gap;
    bit back_to_back;

    // Directed rows. Results are typed in where they are plain: voltages at
    // or beyond supply, resistances just outside either end of the table,
    // and a voltage whose resistance is exactly 140 k, the -30 C point.
    probes[0]  = '{12'd0,    1'b1, 12'sd0,    1'b0};
    probes[1]  = '{12'd4095, 1'b1, 12'sd0,    1'b0};
    probes[2]  = '{12'd3300, 1'b1, 12'sd0,    1'b0};
    probes[3]  = '{12'd3299, 1'b1, 12'sd0,    1'b0};
    probes[4]  = '{12'd125,  1'b1, 12'sd0,    1'b0};
    probes[5]  = '{12'd3173, 1'b1, 12'sd0,    1'b0};
    probes[6]  = '{12'd3080, 1'b1, -12'sd300, 1'b1};
    probes[7]  = '{12'd1,    1'b1, 12'sd0,    1'b0};
    probes[8]  = '{12'd2048, 1'b0, 12'sd0,    1'b0};
    // The warm and cold ends of the table span, just inside.
    probes[9]  = '{12'd126,  1'b0, 12'sd0,    1'b0};
    probes[10] = '{12'd127,  1'b0, 12'sd0,    1'b0};
    probes[11] = '{12'd3172, 1'b0, 12'sd0,    1'b0};
    probes[12] = '{12'd3171, 1'b0, 12'sd0,    1'b0};
    // A spread across the segments, including a 10 k reading at midscale.
    probes[13] = '{12'd200,  1'b0, 12'sd0,    1'b0};
    probes[14] = '{12'd400,  1'b0, 12'sd0,    1'b0};
    probes[15] = '{12'd800,  1'b0, 12'sd0,    1'b0};
    probes[16] = '{12'd1650, 1'b0, 12'sd0,    1'b0};
    probes[17] = '{12'd2500, 1'b0, 12'sd0,    1'b0};
    probes[18] = '{12'd2935, 1'b0, 12'sd0,    1'b0};
    probes[19] = '{12'd3079, 1'b0, 12'sd0,    1'b0};
    probes[20] = '{12'd3081, 1'b0, 12'sd0,    1'b0};
    probes[21] = '{12'd3150, 1'b0, 12'sd0,    1'b0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_PROBES; i++) begin
      send_mv(probes[i].mv, probes[i].known, probes[i].temp, probes[i].in_range);
      idle_for(i % 3 == 0 ? 0 : $urandom_range(0, 2));
    end

    // Random items in blocks of 100. Some blocks run back to back with no
    // idling at all; the others use random gaps.
    back_to_back = 1'b0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) back_to_back = ($urandom_range(0, 2) == 0);
      send_mv(pick_mv(), 1'b0, 12'sd0, 1'b0);
      if (i == RANDOM_ITEMS / 2) begin
        // Hold off the sender until the whole pipeline has emptied.
        start <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
      end else begin
        gap = back_to_back ? 0 : pick_gap();
        idle_for(gap);
      end
    end
    start <= 1'b0;

    while (pending_readings.size() != 0) @(posedge clk);
    // Let any stray strobe show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("thermistor_adc_to_temperature test passed");
    end else begin
      $display("thermistor_adc_to_temperature test failed");
    end
    $finish;
  end

endmodule
